FILE: design/ttlb_pkg.sv
`timescale 1ns / 1ps

package ttlb_pkg;

  // Widths fixed by the request and response formats.
  localparam int PAGE_W = 36;
  localparam int PID_W  = 8;

  // Defaults for the top-level parameters.
  localparam int ENTRIES_DEFAULT   = 16;
  localparam int PAGE_BITS_DEFAULT = 36;

  typedef enum logic {
    CMD_TRANSLATE = 1'b0,
    CMD_ASSOCIATE = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [PAGE_W-1:0] vpn;
    logic [PID_W-1:0]  pid;
    logic [PAGE_W-1:0] new_ppn;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [PAGE_W-1:0] ppn_out;
    logic              evicted;
  } rsp_t;

endpackage

FILE: design/ttlb_cam.sv
`timescale 1ns / 1ps

module ttlb_cam import ttlb_pkg::*; #(
  parameter int ENTRIES   = ENTRIES_DEFAULT,
  parameter int PAGE_BITS = PAGE_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  req_t req,
  output rsp_t rsp
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int PW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;

  logic [ENTRIES-1:0] valid;
  logic [PW-1:0]      vpn_q  [ENTRIES];
  logic [PID_W-1:0]   pid_q  [ENTRIES];
  logic [PW-1:0]      ppn_q  [ENTRIES];
  logic [IW-1:0]      rank   [ENTRIES];
  logic [CW-1:0]      count;

  logic [PW-1:0]      vpn_m;
  logic [PW-1:0]      ppn_m;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] oldest;
  logic [ENTRIES-1:0] free_oh;
  logic [ENTRIES-1:0] slot_oh;
  logic               hit;
  logic               full;
  logic [IW-1:0]      hit_rank;
  logic [PW-1:0]      hit_ppn;
  logic               assoc;

  assign vpn_m = req.vpn[PW-1:0];
  assign ppn_m = req.new_ppn[PW-1:0];
  assign assoc = (req.cmd == CMD_ASSOCIATE);
  assign full  = (count == CW'(ENTRIES));

  // Ranks of the valid entries always form 0 .. count-1, so on a full buffer
  // the least recent entry is the one at the top rank.
  always_comb begin
    hit_rank = '0;
    hit_ppn  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid[i] && (vpn_q[i] == vpn_m) && (pid_q[i] == req.pid);
      oldest[i] = valid[i] && (rank[i] == IW'(ENTRIES - 1));
      hit_rank  = hit_rank | (match[i] ? rank[i] : '0);
      hit_ppn   = hit_ppn | (match[i] ? ppn_q[i] : '0);
    end
  end

  assign hit     = |match;
  // Lowest clear bit of the valid vector.
  assign free_oh = ~valid & (valid + 1'b1);
  assign slot_oh = full ? oldest : free_oh;

  always_comb begin
    rsp.hit     = hit;
    rsp.ppn_out = (!assoc && hit) ? PAGE_W'(hit_ppn) : '0;
    rsp.evicted = assoc && !hit && full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (fire && assoc) begin
      if (hit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (match[i]) begin
            rank[i] <= '0;
          end else if (valid[i] && (rank[i] < hit_rank)) begin
            rank[i] <= rank[i] + 1'b1;
          end
        end
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_oh[i]) begin
            valid[i] <= 1'b1;
            rank[i]  <= '0;
          end else if (valid[i]) begin
            rank[i] <= rank[i] + 1'b1;
          end
        end
        if (!full) begin
          count <= count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && assoc) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit ? match[i] : slot_oh[i]) begin
          ppn_q[i] <= ppn_m;
        end
        if (!hit && slot_oh[i]) begin
          vpn_q[i] <= vpn_m;
          pid_q[i] <= req.pid;
        end
      end
    end
  end

endmodule

FILE: design/tagged_tlb_lru_top.sv
`timescale 1ns / 1ps
// Fully associative translation buffer tagged by virtual page and process id.
// Throughput: one request per cycle unless the result consumer stalls; the single tag
// compare across all entries and the entry update sit between the request register
// and the result register, which holds each result until the consumer takes it.
// Reset (synchronous, active high) clears every entry's valid bit, the recency
// ranks and the fill count; the buffer is usable in the cycle after reset.

module tagged_tlb_lru_top import ttlb_pkg::*; #(
  parameter int ENTRIES   = ENTRIES_DEFAULT,
  parameter int PAGE_BITS = PAGE_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  // Request register: holds one accepted request until it can be looked up.
  logic s1_valid;
  req_t s1_req;
  // The request is looked up, and the entries updated, in the cycle it moves
  // into the result register, so consecutive requests always see the state
  // left by the previous one.
  logic s1_adv;
  rsp_t cam_rsp;

  assign s1_adv    = s1_valid && (!rsp_valid || !rsp_stall);
  // A new request is taken whenever the request register is empty or is
  // emptying this cycle, even while a finished result waits downstream.
  assign req_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1_req <= req;
    end
  end

  ttlb_cam #(
    .ENTRIES   (ENTRIES),
    .PAGE_BITS (PAGE_BITS)
  ) u_cam (
    .clk  (clk),
    .rst  (rst),
    .fire (s1_adv),
    .req  (s1_req),
    .rsp  (cam_rsp)
  );

  // Result register: a held result stays put while the consumer stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp <= cam_rsp;
    end
  end

endmodule
